// ===== rtl/csag_pkg.sv =====
// Shared types, constants and the window legalisation function for the crop address generator.
package csag_pkg;

	localparam int unsigned DIV_STEPS = 11;
	localparam logic [10:0] MAX_AXIS = 11'd1024;

	// Configuration register indexes
	localparam logic [3:0] REG_SIZE_I   = 4'd0;
	localparam logic [3:0] REG_SIZE_J   = 4'd1;
	localparam logic [3:0] REG_SIZE_K   = 4'd2;
	localparam logic [3:0] REG_WINDOW_I = 4'd3;
	localparam logic [3:0] REG_WINDOW_J = 4'd4;
	localparam logic [3:0] REG_WINDOW_K = 4'd5;
	localparam logic [3:0] REG_STRIDE   = 4'd6;
	localparam logic [3:0] REG_FULL     = 4'd7;

	// Axis selectors used during setup
	localparam logic [1:0] AXIS_I = 2'd0;
	localparam logic [1:0] AXIS_J = 2'd1;
	localparam logic [1:0] AXIS_K = 2'd2;

	typedef enum logic [1:0] {
		ST_SETUP,
		ST_DIVIDE,
		ST_READY
	} csag_state_t;

	typedef struct packed {
		logic [10:0] size;
		logic [10:0] first;
		logic [10:0] last;
		logic        adj;
	} axis_t;

	typedef struct packed {
		logic       div_start;
		logic       load_axis;
		logic [1:0] axis_sel;
		logic       item_en;
	} csag_cmd_t;

	typedef struct packed {
		logic div_done;
	} csag_sts_t;

	function automatic axis_t legalise(input logic [10:0] size_reg, input logic [21:0] win,
			input logic full);
		axis_t       a;
		logic [10:0] s;
		logic [10:0] f;
		logic [10:0] l;
		s = size_reg;
		if (s == 11'd0) s = 11'd1;
		if (s > MAX_AXIS) s = MAX_AXIS;
		a.size  = s;
		a.adj   = 1'b0;
		a.first = 11'd1;
		a.last  = s;
		if (!full) begin
			f = win[10:0];
			l = win[21:11];
			if (f == 11'd0) begin
				f = 11'd1;
				a.adj = 1'b1;
			end
			if (l == 11'd0) begin
				l = 11'd1;
				a.adj = 1'b1;
			end
			if (f > s) begin
				f = 11'd1;
				a.adj = 1'b1;
			end
			if (l > s) begin
				l = s;
				a.adj = 1'b1;
			end
			if (f > l) begin
				a.first = l;
				a.last  = f;
				a.adj   = 1'b1;
			end else begin
				a.first = f;
				a.last  = l;
			end
		end
		return a;
	endfunction

endpackage

// ===== rtl/csag_div.sv =====
// Restoring divider, one quotient bit per cycle, for the per-axis sample counts.
module csag_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [10:0] dividend,
	input  logic [9:0]  divisor,
	output logic        done,
	output logic [10:0] quotient
);

	logic [9:0]  rem_q;
	logic [10:0] quo_q;
	logic [9:0]  den_q;
	logic [3:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [10:0] trial;
	logic [10:0] diff;
	logic        ge;

	assign trial = {rem_q, quo_q[10]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(csag_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[9:0] : trial[9:0];
			quo_q <= {quo_q[9:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/csag_ctrl.sv =====
// Setup sequencer: runs the divider once per axis, then opens the request channel.
module csag_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  csag_pkg::csag_sts_t  sts,
	output csag_pkg::csag_cmd_t  cmd
);

	csag_pkg::csag_state_t state_q;
	csag_pkg::csag_state_t state_d;
	logic [1:0]            ax_q;
	logic [1:0]            ax_d;

	// Next state
	always_comb begin
		state_d = state_q;
		ax_d    = ax_q;
		unique case (state_q)
			csag_pkg::ST_SETUP: begin
				state_d = csag_pkg::ST_DIVIDE;
			end
			csag_pkg::ST_DIVIDE: begin
				if (sts.div_done) begin
					if (ax_q == csag_pkg::AXIS_K) begin
						state_d = csag_pkg::ST_READY;
					end else begin
						state_d = csag_pkg::ST_SETUP;
						ax_d    = ax_q + 2'd1;
					end
				end
			end
			csag_pkg::ST_READY: begin
				state_d = csag_pkg::ST_READY;
			end
			default: begin
				state_d = csag_pkg::ST_SETUP;
			end
		endcase
		// A configuration write always restarts setup from the i axis
		if (cfg_we) begin
			state_d = csag_pkg::ST_SETUP;
			ax_d    = csag_pkg::AXIS_I;
		end
	end

	// Outputs
	always_comb begin
		cmd          = '0;
		cmd.axis_sel = ax_q;
		unique case (state_q)
			csag_pkg::ST_SETUP:  cmd.div_start = 1'b1;
			csag_pkg::ST_DIVIDE: cmd.load_axis = sts.div_done;
			csag_pkg::ST_READY:  cmd.item_en   = 1'b1;
			default:             cmd.item_en   = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csag_pkg::ST_SETUP;
			ax_q    <= csag_pkg::AXIS_I;
		end else begin
			state_q <= state_d;
			ax_q    <= ax_d;
		end
	end

endmodule

// ===== rtl/csag_dp.sv =====
// Datapath: axis setup registers, point counters and the address pipeline.
module csag_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  csag_pkg::csag_cmd_t  cmd,
	output csag_pkg::csag_sts_t  sts,
	input  logic [10:0]          grid_size_i,
	input  logic [10:0]          grid_size_j,
	input  logic [10:0]          grid_size_k,
	input  logic [21:0]          window_i,
	input  logic [21:0]          window_j,
	input  logic [21:0]          window_k,
	input  logic [9:0]           stride,
	input  logic                 full_extent,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic                 restart,
	output logic                 addr_valid,
	input  logic                 addr_stall,
	output logic                 valid_res,
	output logic [29:0]          src_index,
	output logic [29:0]          dst_index,
	output logic                 last,
	output logic [2:0]           adjusted
);

	// ---------------- setup ----------------
	logic [9:0]      st_eff;
	csag_pkg::axis_t leg;
	logic [10:0]     quo;
	logic            div_done;

	csag_pkg::axis_t ax_i_q, ax_j_q, ax_k_q;
	logic [10:0]     n_i_q, n_j_q, n_k_q;

	assign st_eff = (stride == 10'd0) ? 10'd1 : stride;

	always_comb begin
		unique case (cmd.axis_sel)
			csag_pkg::AXIS_I: leg = csag_pkg::legalise(grid_size_i, window_i, full_extent);
			csag_pkg::AXIS_J: leg = csag_pkg::legalise(grid_size_j, window_j, full_extent);
			default:          leg = csag_pkg::legalise(grid_size_k, window_k, full_extent);
		endcase
	end

	csag_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (leg.last - leg.first),
		.divisor  (st_eff),
		.done     (div_done),
		.quotient (quo)
	);

	assign sts.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.load_axis) begin
			unique case (cmd.axis_sel)
				csag_pkg::AXIS_I: begin
					ax_i_q <= leg;
					n_i_q  <= quo + 11'd1;
				end
				csag_pkg::AXIS_J: begin
					ax_j_q <= leg;
					n_j_q  <= quo + 11'd1;
				end
				default: begin
					ax_k_q <= leg;
					n_k_q  <= quo + 11'd1;
				end
			endcase
		end
	end

	logic [10:0] nm1_i, nm1_j, nm1_k;
	assign nm1_i = n_i_q - 11'd1;
	assign nm1_j = n_j_q - 11'd1;
	assign nm1_k = n_k_q - 11'd1;

	// ---------------- flow control ----------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic accept;

	assign rdy5      = !v_s5 || !addr_stall;
	assign rdy4      = !v_s4 || rdy5;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign cmd_stall = !(cmd.item_en && rdy1);
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= accept;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// ---------------- point counters ----------------
	logic [10:0] cnt_i_q, cnt_j_q, cnt_k_q;
	logic [29:0] oc_q;
	logic        running_q;

	logic [10:0] ci, cj, ck;
	logic [29:0] oc;
	logic        run_eff;
	logic        fin;
	logic [10:0] ci_d, cj_d, ck_d;
	logic [29:0] oc_d;

	always_comb begin
		ci      = restart ? 11'd0 : cnt_i_q;
		cj      = restart ? 11'd0 : cnt_j_q;
		ck      = restart ? 11'd0 : cnt_k_q;
		oc      = restart ? 30'd0 : oc_q;
		run_eff = restart || running_q;
		fin     = run_eff && (ci >= nm1_i) && (cj >= nm1_j) && (ck >= nm1_k);
		ci_d    = ci;
		cj_d    = cj;
		ck_d    = ck;
		oc_d    = oc;
		if (run_eff && !fin) begin
			oc_d = oc + 30'd1;
			if (ck + 11'd1 < n_k_q) begin
				ck_d = ck + 11'd1;
			end else begin
				ck_d = 11'd0;
				if (cj + 11'd1 < n_j_q) begin
					cj_d = cj + 11'd1;
				end else begin
					cj_d = 11'd0;
					ci_d = ci + 11'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_i_q   <= '0;
			cnt_j_q   <= '0;
			cnt_k_q   <= '0;
			oc_q      <= '0;
			running_q <= 1'b0;
		end else if (accept) begin
			cnt_i_q   <= ci_d;
			cnt_j_q   <= cj_d;
			cnt_k_q   <= ck_d;
			oc_q      <= oc_d;
			running_q <= run_eff && !fin;
		end
	end

	// ---------------- address pipeline ----------------
	logic        run_s1, run_s2, run_s3, run_s4, run_s5;
	logic [10:0] ci_s1, cj_s1, ck_s1;
	logic [29:0] dst_s1, dst_s2, dst_s3, dst_s4, dst_s5;
	logic        fin_s1, fin_s2, fin_s3, fin_s4, fin_s5;
	logic [2:0]  adj_s1, adj_s2, adj_s3, adj_s4, adj_s5;
	logic [20:0] pi_s2, pj_s2, pk_s2;
	logic        snap_i_s2, snap_j_s2, snap_k_s2;
	logic [10:0] si_s3, sj_s3, sk_s3;
	logic [21:0] t1_s4;
	logic [10:0] sk_s4;
	logic [29:0] src_s5;
	logic [32:0] src_full;

	assign src_full = 33'(t1_s4) * 33'(ax_k_q.size) + 33'(sk_s4);

	always_ff @(posedge clk) begin
		if (accept) begin
			run_s1 <= run_eff;
			ci_s1  <= ci;
			cj_s1  <= cj;
			ck_s1  <= ck;
			dst_s1 <= run_eff ? oc : 30'd0;
			fin_s1 <= fin;
			adj_s1 <= run_eff ? {ax_k_q.adj, ax_j_q.adj, ax_i_q.adj} : 3'd0;
		end
		if (v_s1 && rdy2) begin
			run_s2    <= run_s1;
			dst_s2    <= dst_s1;
			fin_s2    <= fin_s1;
			adj_s2    <= adj_s1;
			pi_s2     <= 21'(st_eff) * 21'(ci_s1);
			pj_s2     <= 21'(st_eff) * 21'(cj_s1);
			pk_s2     <= 21'(st_eff) * 21'(ck_s1);
			snap_i_s2 <= ci_s1 >= nm1_i;
			snap_j_s2 <= cj_s1 >= nm1_j;
			snap_k_s2 <= ck_s1 >= nm1_k;
		end
		if (v_s2 && rdy3) begin
			run_s3 <= run_s2;
			dst_s3 <= dst_s2;
			fin_s3 <= fin_s2;
			adj_s3 <= adj_s2;
			si_s3  <= snap_i_s2 ? ax_i_q.last - 11'd1 : ax_i_q.first - 11'd1 + pi_s2[10:0];
			sj_s3  <= snap_j_s2 ? ax_j_q.last - 11'd1 : ax_j_q.first - 11'd1 + pj_s2[10:0];
			sk_s3  <= snap_k_s2 ? ax_k_q.last - 11'd1 : ax_k_q.first - 11'd1 + pk_s2[10:0];
		end
		if (v_s3 && rdy4) begin
			run_s4 <= run_s3;
			dst_s4 <= dst_s3;
			fin_s4 <= fin_s3;
			adj_s4 <= adj_s3;
			t1_s4  <= 22'(si_s3) * 22'(ax_j_q.size) + 22'(sj_s3);
			sk_s4  <= sk_s3;
		end
		if (v_s4 && rdy5) begin
			run_s5 <= run_s4;
			dst_s5 <= dst_s4;
			fin_s5 <= fin_s4;
			adj_s5 <= adj_s4;
			src_s5 <= run_s4 ? src_full[29:0] : 30'd0;
		end
	end

	assign addr_valid = v_s5;
	assign valid_res  = run_s5;
	assign src_index  = src_s5;
	assign dst_index  = dst_s5;
	assign last       = fin_s5;
	assign adjusted   = adj_s5;

endmodule

// ===== rtl/crop_subsample_address_gen.sv =====
// Top level of the crop and subsample gather address generator.
// The five-stage address pipeline registers each accepted request through stages s1 to s5.
// Throughput: one request per cycle once setup is done and addr_stall is low.
// Setup: runs after reset and after every configuration write, one axis at a time through the
// one-bit-per-cycle sample-count divider; requests are stalled meanwhile.
// Reset: registers take their documented values, no crop is running, the pipeline is empty.
module crop_subsample_address_gen (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [21:0] cfg_data,
	// request channel
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        restart,
	// address channel
	output logic        addr_valid,
	input  logic        addr_stall,
	output logic        valid_res,
	output logic [29:0] src_index,
	output logic [29:0] dst_index,
	output logic        last,
	output logic [2:0]  adjusted
);

	logic [10:0] size_i_q, size_j_q, size_k_q;
	logic [21:0] win_i_q, win_j_q, win_k_q;
	logic [9:0]  stride_q;
	logic        full_q;
	logic        cfg_we;

	csag_pkg::csag_cmd_t cmd;
	csag_pkg::csag_sts_t sts;

	// Writes are always taken; the sequencer reruns setup after each one
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Hold the configuration; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_i_q <= 11'd1;
			size_j_q <= 11'd1;
			size_k_q <= 11'd1;
			win_i_q  <= 22'd204801;
			win_j_q  <= 22'd204801;
			win_k_q  <= 22'd204801;
			stride_q <= 10'd2;
			full_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csag_pkg::REG_SIZE_I:   size_i_q <= cfg_data[10:0];
				csag_pkg::REG_SIZE_J:   size_j_q <= cfg_data[10:0];
				csag_pkg::REG_SIZE_K:   size_k_q <= cfg_data[10:0];
				csag_pkg::REG_WINDOW_I: win_i_q  <= cfg_data;
				csag_pkg::REG_WINDOW_J: win_j_q  <= cfg_data;
				csag_pkg::REG_WINDOW_K: win_k_q  <= cfg_data;
				csag_pkg::REG_STRIDE:   stride_q <= cfg_data[9:0];
				csag_pkg::REG_FULL:     full_q   <= cfg_data[0];
				default:                full_q   <= full_q;
			endcase
		end
	end

	// Sequencer: legalise each axis and divide out its sample count, then open requests
	csag_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_we (cfg_we),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Counters walk k innermost; the pipeline turns each point into source and destination
	csag_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.grid_size_i (size_i_q),
		.grid_size_j (size_j_q),
		.grid_size_k (size_k_q),
		.window_i    (win_i_q),
		.window_j    (win_j_q),
		.window_k    (win_k_q),
		.stride      (stride_q),
		.full_extent (full_q),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.restart     (restart),
		.addr_valid  (addr_valid),
		.addr_stall  (addr_stall),
		.valid_res   (valid_res),
		.src_index   (src_index),
		.dst_index   (dst_index),
		.last        (last),
		.adjusted    (adjusted)
	);

endmodule

// ===== rtl/csag_chk.sv =====
// Port-level checker for the crop address generator and its bind.
module csag_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        cmd_stall,
	input logic        addr_valid,
	input logic        addr_stall,
	input logic        valid_res,
	input logic [29:0] src_index,
	input logic [29:0] dst_index,
	input logic        last,
	input logic [2:0]  adjusted
);

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid && addr_stall |=> addr_valid && $stable(src_index) && $stable(dst_index))
		else $error("stalled result changed");

	// The final point is always a produced point
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid && last |-> valid_res)
		else $error("last set on an idle result");

	// An idle result carries zeros
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		addr_valid && !valid_res |-> src_index == 30'd0 && dst_index == 30'd0 && adjusted == 3'd0)
		else $error("idle result not zero");

	// A configuration write sends the block back into setup
	a_setup: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> cmd_stall)
		else $error("requests taken right after a configuration write");

endmodule

bind crop_subsample_address_gen csag_chk u_csag_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.cfg_valid  (cfg_valid),
	.cfg_ready  (cfg_ready),
	.cmd_stall  (cmd_stall),
	.addr_valid (addr_valid),
	.addr_stall (addr_stall),
	.valid_res  (valid_res),
	.src_index  (src_index),
	.dst_index  (dst_index),
	.last       (last),
	.adjusted   (adjusted)
);

// ===== tb/crop_subsample_address_gen_test.sv =====
// Self-checking testbench for the crop and subsample gather address generator.
`timescale 1ns / 1ps

module crop_subsample_address_gen_test;

	localparam int          ITEM_TARGET      = 1950;
	localparam int          CYCLE_LIMIT      = 400000;
	localparam int          HOLD_OFF_CYCLES  = 300;
	localparam int          HOLD_OFF_PHASE   = 5;
	localparam int          SETTLE_CYCLES    = 8;
	localparam logic [3:0]  FIRST_UNUSED_REG = csag_pkg::REG_FULL + 4'd1;

	// One point on the address channel
	typedef struct packed {
		logic        valid_res;
		logic [29:0] src;
		logic [29:0] dst;
		logic        last;
		logic [2:0]  adjusted;
	} crop_point_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HALF,
		STALL_HEAVY
	} stall_mode_t;

	// Tracks the register file and the crop counters, works out the point that each
	// accepted request must produce and holds those points until they come out.
	class crop_address_book;
		typedef struct {
			int unsigned size;
			int unsigned first;
			int unsigned last;
			int unsigned n;
			bit          adj;
		} axis_span_t;

		logic [10:0] size_reg [3];
		logic [21:0] window_reg [3];
		logic [9:0]  stride_reg;
		logic        full_reg;
		logic [10:0] count [3];
		logic [29:0] points_out;
		bit          crop_running;
		crop_point_t pending_points [$];
		int          requests_taken;
		int          mismatches;

		function new();
			foreach (size_reg[a]) begin
				size_reg[a]   = 11'd1;
				window_reg[a] = {11'd100, 11'd1};
				count[a]      = 11'd0;
			end
			stride_reg     = 10'd2;
			full_reg       = 1'b0;
			points_out     = 30'd0;
			crop_running   = 1'b0;
			requests_taken = 0;
			mismatches     = 0;
		endfunction

		function void write_reg(input logic [3:0] idx, input logic [21:0] data);
			case (idx)
				csag_pkg::REG_SIZE_I:   size_reg[csag_pkg::AXIS_I] = data[10:0];
				csag_pkg::REG_SIZE_J:   size_reg[csag_pkg::AXIS_J] = data[10:0];
				csag_pkg::REG_SIZE_K:   size_reg[csag_pkg::AXIS_K] = data[10:0];
				csag_pkg::REG_WINDOW_I: window_reg[csag_pkg::AXIS_I] = data;
				csag_pkg::REG_WINDOW_J: window_reg[csag_pkg::AXIS_J] = data;
				csag_pkg::REG_WINDOW_K: window_reg[csag_pkg::AXIS_K] = data;
				csag_pkg::REG_STRIDE:   stride_reg = data[9:0];
				csag_pkg::REG_FULL:     full_reg = data[0];
				default: ;
			endcase
		endfunction

		// Clamp the window to the grid, swap reversed bounds, count the samples
		function axis_span_t fit_axis(input logic [10:0] size_raw, input logic [21:0] win,
				input int unsigned st);
			axis_span_t  ax;
			int unsigned s, f, l, t;
			s = size_raw;
			if (s == 0) s = 1;
			if (s > csag_pkg::MAX_AXIS) s = csag_pkg::MAX_AXIS;
			ax.size = s;
			ax.adj  = 1'b0;
			if (full_reg) begin
				f = 1;
				l = s;
			end else begin
				f = win[10:0];
				l = win[21:11];
				if (f == 0) begin
					f = 1;
					ax.adj = 1'b1;
				end
				if (l == 0) begin
					l = 1;
					ax.adj = 1'b1;
				end
				if (f > s) begin
					f = 1;
					ax.adj = 1'b1;
				end
				if (l > s) begin
					l = s;
					ax.adj = 1'b1;
				end
				if (f > l) begin
					t = f;
					f = l;
					l = t;
					ax.adj = 1'b1;
				end
			end
			ax.first = f;
			ax.last  = l;
			ax.n     = 1 + (l - f) / st;
			return ax;
		endfunction

		function void take_request(input logic rs);
			axis_span_t  ax [3];
			int unsigned pos [3];
			int unsigned st;
			logic [63:0] src;
			bit          fin;
			crop_point_t p;
			st = (stride_reg == 10'd0) ? 1 : stride_reg;
			foreach (ax[a]) ax[a] = fit_axis(size_reg[a], window_reg[a], st);
			requests_taken++;
			p = '0;
			if (rs) begin
				foreach (count[a]) count[a] = 11'd0;
				points_out   = 30'd0;
				crop_running = 1'b1;
			end
			if (!crop_running) begin
				pending_points.push_back(p);
				return;
			end
			fin = 1'b1;
			foreach (ax[a]) begin
				if (count[a] >= ax[a].n - 1) begin
					pos[a] = ax[a].last - 1;
				end else begin
					pos[a] = ax[a].first - 1 + st * count[a];
					fin    = 1'b0;
				end
			end
			src = (64'(pos[csag_pkg::AXIS_I]) * ax[csag_pkg::AXIS_J].size
				+ pos[csag_pkg::AXIS_J]) * ax[csag_pkg::AXIS_K].size + pos[csag_pkg::AXIS_K];
			p.valid_res = 1'b1;
			p.src       = src[29:0];
			p.dst       = points_out;
			p.last      = fin;
			p.adjusted  = {ax[csag_pkg::AXIS_K].adj, ax[csag_pkg::AXIS_J].adj,
				ax[csag_pkg::AXIS_I].adj};
			pending_points.push_back(p);
			if (fin) begin
				crop_running = 1'b0;
			end else begin
				points_out++;
				if (count[csag_pkg::AXIS_K] + 1 < ax[csag_pkg::AXIS_K].n) begin
					count[csag_pkg::AXIS_K]++;
				end else begin
					count[csag_pkg::AXIS_K] = 11'd0;
					if (count[csag_pkg::AXIS_J] + 1 < ax[csag_pkg::AXIS_J].n) begin
						count[csag_pkg::AXIS_J]++;
					end else begin
						count[csag_pkg::AXIS_J] = 11'd0;
						count[csag_pkg::AXIS_I]++;
					end
				end
			end
		endfunction

		function void note_fault(input string msg);
			mismatches++;
			if (mismatches <= 10) $display("%s", msg);
		endfunction

		function void match_point(input logic v, input logic [29:0] s, input logic [29:0] d,
				input logic l, input logic [2:0] adj);
			crop_point_t want;
			if (pending_points.size() == 0) begin
				note_fault($sformatf("unexpected address: valid %0b src %0d dst %0d last %0b adj %0h",
					v, s, d, l, adj));
				return;
			end
			want = pending_points.pop_front();
			if (want.valid_res !== v || want.src !== s || want.dst !== d || want.last !== l
					|| want.adjusted !== adj)
				note_fault($sformatf({"address mismatch: expected valid %0b src %0d dst %0d",
					" last %0b adj %0h, got valid %0b src %0d dst %0d last %0b adj %0h"},
					want.valid_res, want.src, want.dst, want.last, want.adjusted,
					v, s, d, l, adj));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_index;
	logic [21:0] cfg_data;
	logic        cmd_valid;
	logic        cmd_stall;
	logic        restart;
	logic        addr_valid;
	logic        addr_stall;
	logic        valid_res;
	logic [29:0] src_index;
	logic [29:0] dst_index;
	logic        last;
	logic [2:0]  adjusted;

	crop_address_book sb = new();
	bit               hold_off_due = 1'b0;
	int               cycle_count = 0;

	crop_subsample_address_gen u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.restart    (restart),
		.addr_valid (addr_valid),
		.addr_stall (addr_stall),
		.valid_res  (valid_res),
		.src_index  (src_index),
		.dst_index  (dst_index),
		.last       (last),
		.adjusted   (adjusted)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up if the run stalls; the limit is many times the slowest clean run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("crop_subsample_address_gen verification failed");
		$finish;
	end

	// Pack a window register from its 1-based bounds
	function automatic logic [21:0] span(input logic [10:0] first, input logic [10:0] last_idx);
		return {last_idx, first};
	endfunction

	// Window bound near the grid, sometimes zero or anywhere in the field
	function automatic logic [10:0] pick_bound(input int unsigned s);
		case ($urandom_range(0, 7))
			0:       return 11'd0;
			1:       return 11'($urandom);
			default: return 11'($urandom_range(1, s + 1));
		endcase
	endfunction

	// Grid size at or past the limits of the axis
	function automatic logic [10:0] rough_size();
		case ($urandom_range(0, 4))
			0:       return 11'd0;
			1:       return 11'd1;
			2:       return csag_pkg::MAX_AXIS;
			3:       return 11'd2047;
			default: return 11'($urandom);
		endcase
	endfunction

	function automatic logic [21:0] far_window();
		if ($urandom_range(0, 1)) return 22'($urandom);
		return span(pick_bound(csag_pkg::MAX_AXIS), pick_bound(csag_pkg::MAX_AXIS));
	endfunction

	// Write one register; valid stays up so back-to-back writes need no gap
	task automatic set_reg(input logic [3:0] idx, input logic [21:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.write_reg(idx, data);
	endtask

	// Load every register; spare high bits carry noise the block must drop
	task automatic configure(input logic [10:0] size_i, input logic [10:0] size_j,
			input logic [10:0] size_k, input logic [21:0] win_i, input logic [21:0] win_j,
			input logic [21:0] win_k, input logic [9:0] st, input logic full);
		if ($urandom_range(0, 2) == 0)
			set_reg(FIRST_UNUSED_REG + 4'($urandom_range(0, 7)), 22'($urandom));
		set_reg(csag_pkg::REG_SIZE_I, {11'($urandom), size_i});
		set_reg(csag_pkg::REG_SIZE_J, {11'($urandom), size_j});
		set_reg(csag_pkg::REG_SIZE_K, {11'($urandom), size_k});
		set_reg(csag_pkg::REG_WINDOW_I, win_i);
		set_reg(csag_pkg::REG_WINDOW_J, win_j);
		set_reg(csag_pkg::REG_WINDOW_K, win_k);
		set_reg(csag_pkg::REG_STRIDE, {12'($urandom), st});
		set_reg(csag_pkg::REG_FULL, {21'($urandom), full});
		cfg_valid <= 1'b0;
	endtask

	// Offer one request and hold it until the block takes it
	task automatic offer_request(input logic rs);
		cmd_valid <= 1'b1;
		restart   <= rs;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		sb.take_request(rs);
	endtask

	// Random requests in bursts; mostly advance a running crop, restart an idle one
	task automatic stream_requests(input int n);
		int burst;
		int gap;
		burst = $urandom_range(1, 24);
		repeat (n) begin
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
				if (gap != 0) begin
					cmd_valid <= 1'b0;
					restart   <= 1'($urandom);
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 24);
			end
			offer_request(sb.crop_running ? ($urandom_range(0, 40) == 0)
				: ($urandom_range(0, 7) != 0));
			burst--;
		end
	endtask

	// Drop valid, wait for every outstanding point, then let the pipeline go quiet
	task automatic settle();
		cmd_valid <= 1'b0;
		while (sb.pending_points.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver: stall in segments of varying density, with one long hold-off
	initial begin : receiver
		stall_mode_t mode;
		int          seg_left;
		bit          held_off;
		mode     = STALL_NONE;
		seg_left = 0;
		held_off = 1'b0;
		forever begin
			if (hold_off_due && !held_off) begin
				held_off = 1'b1;
				addr_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			if (seg_left == 0) begin
				mode     = stall_mode_t'($urandom_range(0, 3));
				seg_left = $urandom_range(8, 60);
			end
			seg_left--;
			case (mode)
				STALL_NONE:  addr_stall <= 1'b0;
				STALL_LIGHT: addr_stall <= ($urandom_range(0, 3) == 0);
				STALL_HALF:  addr_stall <= 1'($urandom);
				default:     addr_stall <= ($urandom_range(0, 3) != 0);
			endcase
			@(posedge clk);
		end
	end

	// Check each point as it is taken on the address channel
	always @(posedge clk) begin
		if (arst_n === 1'b1 && addr_valid === 1'b1 && addr_stall === 1'b0)
			sb.match_point(valid_res, src_index, dst_index, last, adjusted);
	end

	initial begin : stimulus
		int          sent;
		int          n;
		int          phase;
		logic [10:0] si, sj, sk;
		sent  = 0;
		phase = 0;
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= csag_pkg::REG_SIZE_I;
		cfg_data  <= 22'd0;
		cmd_valid <= 1'b0;
		restart   <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: idle request, then single-point crops clamped on every axis
		offer_request(1'b0);
		offer_request(1'b1);
		offer_request(1'b0);
		offer_request(1'b1);
		settle();

		// Zero and oversized grids, zero bounds, bounds past the grid, reversed
		// bounds, stride zero; leave the crop running
		configure(11'd0, 11'd2047, 11'd5, span(11'd0, 11'd0), span(11'd2000, 11'd1500),
			span(11'd5, 11'd2), 10'd0, 1'b0);
		offer_request(1'b1);
		repeat (4) offer_request(1'b0);
		settle();

		// Full extent with the largest stride under a running crop: one point per axis,
		// so the counters already sit past the end and the next point is final
		configure(11'd3, 11'd2, 11'd4, span(11'd7, 11'd3), span(11'd0, 11'd9),
			span(11'd1, 11'd1), 10'd1023, 1'b1);
		offer_request(1'b0);
		offer_request(1'b0);
		offer_request(1'b1);
		settle();

		// First beyond the grid on every axis: whole 2x2x3 grid, walked to the end
		configure(11'd2, 11'd2, 11'd3, span(11'd2047, 11'd2047), span(11'd2047, 11'd2047),
			span(11'd2047, 11'd2047), 10'd1, 1'b0);
		offer_request(1'b1);
		repeat (11) offer_request(1'b0);
		settle();

		// Far corner of the largest grid: source index reaches the top of its range
		configure(csag_pkg::MAX_AXIS, csag_pkg::MAX_AXIS, csag_pkg::MAX_AXIS,
			span(csag_pkg::MAX_AXIS, csag_pkg::MAX_AXIS),
			span(csag_pkg::MAX_AXIS, csag_pkg::MAX_AXIS),
			span(11'd1020, csag_pkg::MAX_AXIS), 10'd3, 1'b0);
		offer_request(1'b1);
		offer_request(1'b0);
		settle();

		// Random phases: mostly small grids so crops finish, now and then extremes
		while (sent < ITEM_TARGET) begin
			if (phase != HOLD_OFF_PHASE && $urandom_range(0, 9) == 0) begin
				configure(rough_size(), rough_size(), rough_size(), far_window(), far_window(),
					far_window(), ($urandom_range(0, 1) ? 10'd1023 : 10'($urandom)),
					1'($urandom));
				n = $urandom_range(10, 30);
			end else begin
				si = 11'($urandom_range(0, 9));
				sj = 11'($urandom_range(0, 9));
				sk = 11'($urandom_range(0, 9));
				configure(si, sj, sk, span(pick_bound(si), pick_bound(si)),
					span(pick_bound(sj), pick_bound(sj)), span(pick_bound(sk), pick_bound(sk)),
					(($urandom_range(0, 9) == 0) ? 10'd1023 : 10'($urandom_range(0, 4))),
					($urandom_range(0, 3) == 0));
				n = $urandom_range(30, 90);
			end
			// Starve the address side for a while so the block backs up onto requests
			if (phase == HOLD_OFF_PHASE) begin
				hold_off_due = 1'b1;
				n = 200;
			end
			stream_requests(n);
			sent += n;
			phase++;
			settle();
		end

		repeat (12) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
			$display("crop_subsample_address_gen verification clean");
		end else begin
			$display("crop_subsample_address_gen verification failed");
		end
		$finish;
	end

endmodule
